// ===== src/dkts_pkg.sv =====
// ============================================================================
// dkts_pkg - shared definitions of the descending key/tag sorter
// Tag width, sequencer states and the control group of the max tracker.
// ============================================================================
package dkts_pkg;

   localparam int TAG_BITS = 6;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_LOAD      = 6'b000001,
      S_SCAN      = 6'b000010,
      S_SWAP_A    = 6'b000100,
      S_SWAP_B    = 6'b001000,
      S_EMIT_RD   = 6'b010000,
      S_EMIT_DATA = 6'b100000
   } state_type;

   // control of the running maximum during one scan pass
   typedef struct packed {
      logic clear;   // first entry of the pass: load base and best
      logic sample;  // later entry: take it if strictly greater
   } track_ctl_type;

endpackage

// ===== src/dkts_pair_ram.sv =====
// ============================================================================
// dkts_pair_ram - key/tag pair store
// Single write port, single read port, registered read data held between reads.
// ============================================================================
module dkts_pair_ram
#(
   parameter int DATA_BITS = 22,
   parameter int DEPTH     = 64,
   localparam int AW       = $clog2(DEPTH)
)
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dkts_max_tracker.sv =====
// ============================================================================
// dkts_max_tracker - running maximum of one selection pass
// Keeps the front entry of the pass and the first strictly greatest entry.
// ============================================================================
module dkts_max_tracker
   import dkts_pkg::*;
#(
   parameter int KEY_BITS = 16,
   parameter int AW       = 6
)
(
   input  logic                clock,
   input  track_ctl_type       ctl,
   input  logic [KEY_BITS-1:0] rd_key,
   input  logic [TAG_BITS-1:0] rd_tag,
   input  logic [AW-1:0]       rd_idx,
   output logic [KEY_BITS-1:0] best_key,
   output logic [TAG_BITS-1:0] best_tag,
   output logic [AW-1:0]       best_idx,
   output logic [KEY_BITS-1:0] base_key,
   output logic [TAG_BITS-1:0] base_tag
);

   logic [KEY_BITS-1:0] best_key_ff;
   logic [TAG_BITS-1:0] best_tag_ff;
   logic [AW-1:0]       best_idx_ff;
   logic [KEY_BITS-1:0] base_key_ff;
   logic [TAG_BITS-1:0] base_tag_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         best_key_ff <= rd_key;
         best_tag_ff <= rd_tag;
         best_idx_ff <= rd_idx;
         base_key_ff <= rd_key;
         base_tag_ff <= rd_tag;
      end else if (ctl.sample && ($signed(rd_key) > $signed(best_key_ff))) begin
         best_key_ff <= rd_key;
         best_tag_ff <= rd_tag;
         best_idx_ff <= rd_idx;
      end
   end

   assign best_key = best_key_ff;
   assign best_tag = best_tag_ff;
   assign best_idx = best_idx_ff;
   assign base_key = base_key_ff;
   assign base_tag = base_tag_ff;

endmodule

// ===== src/descending_key_tag_sorter.sv =====
// ============================================================================
// descending_key_tag_sorter - list loader, selection sorter and emitter
// Collects signed key/tag pairs, sorts them in descending key order in place
// in one pair memory and streams the sorted list back out.
// ============================================================================
//
//   channel | direction | tdata (low bit up)        | tlast        | tuser
//   --------+-----------+---------------------------+--------------+---------
//   req_    | in        | sort_key, item_tag, zeros | last_item    | -
//   rsp_    | out       | sorted_key, sorted_tag,   | final_result | overflow
//           |           | zeros                     |              |
//
// Rate: one loaded request per cycle while loading. For a list of n pairs, sort
// pass p (p = 0 .. n-2) issues one memory read per entry of the tail, drains
// the read pipe and makes two writes for the swap through the single write
// port. Emission reads each result, then loads it into the output register.
// Reset: synchronous, clears the sequencer, count, overflow flag and rsp_tvalid;
// the memory is not cleared, only entries written in the current list are read.
// Stalls: req_tready is high only while loading; a held result blocks only
// the next output load, and the block resumes loading while the final result
// still waits.
//
module descending_key_tag_sorter
   import dkts_pkg::*;
#(
   parameter int LIST_DEPTH = 64,
   parameter int KEY_BITS   = 16,
   localparam int DW        = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [DW-1:0] req_tdata,    // sort_key, item_tag, zero fill
   input  logic          req_tlast,    // last_item
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [DW-1:0] rsp_tdata,    // sorted_key, sorted_tag, zero fill
   output logic          rsp_tlast,    // final_result
   output logic          rsp_tuser     // overflow
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int PW = KEY_BITS + TAG_BITS;

   // sequencer and pointers
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;   // pairs in the current list
   logic          ovf_ff, ovf_in;       // a pair of this list was dropped
   logic [AW-1:0] pos_ff, pos_in;       // front position of the sort pass
   logic [CW-1:0] ptr_ff, ptr_in;       // scan read pointer, emit pointer
   logic          rdv_ff, rdv_in;       // read data of a scan is valid
   logic [AW-1:0] rdi_ff, rdi_in;       // index of that read data

   // output register
   logic                rsp_valid_ff;
   logic [KEY_BITS-1:0] rsp_key_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;
   logic                rsp_last_ff;
   logic                rsp_ovf_ff;

   // memory port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] wr_data, rd_data;

   // tracker
   track_ctl_type       trk_ctl;
   logic [KEY_BITS-1:0] best_key, base_key;
   logic [TAG_BITS-1:0] best_tag, base_tag;
   logic [AW-1:0]       best_idx;

   logic          load_fire, store, out_free, emit_load;
   logic [CW-1:0] n_after;

   assign req_tready = (state_ff == S_LOAD);
   assign load_fire  = req_tvalid && req_tready;
   // drop the pair once the store is full
   assign store      = load_fire && (count_ff < CW'(LIST_DEPTH));
   assign n_after    = store ? count_ff + CW'(1) : count_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   dkts_pair_ram #(
      .DATA_BITS (PW),
      .DEPTH     (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dkts_max_tracker #(
      .KEY_BITS (KEY_BITS),
      .AW       (AW)
   ) u_tracker (
      .clock    (clock),
      .ctl      (trk_ctl),
      .rd_key   (rd_data[KEY_BITS-1:0]),
      .rd_tag   (rd_data[PW-1:KEY_BITS]),
      .rd_idx   (rdi_ff),
      .best_key (best_key),
      .best_tag (best_tag),
      .best_idx (best_idx),
      .base_key (base_key),
      .base_tag (base_tag)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      pos_in    = pos_ff;
      ptr_in    = ptr_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = {req_tdata[PW-1:KEY_BITS], req_tdata[KEY_BITS-1:0]};
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];
      trk_ctl   = '0;
      emit_load = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (load_fire) begin
               wr_en    = store;
               count_in = n_after;
               ovf_in   = ovf_ff || !store;
               if (req_tlast) begin
                  // a single pair needs no sorting
                  pos_in   = '0;
                  ptr_in   = '0;
                  state_in = (n_after >= CW'(2)) ? S_SCAN : S_EMIT_RD;
               end
            end
         end
         S_SCAN: begin
            // issue one read a cycle over the tail, front entry first
            if (ptr_ff < count_ff) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + CW'(1);
            end
            trk_ctl.clear  = rdv_ff && (rdi_ff == pos_ff);
            trk_ctl.sample = rdv_ff && (rdi_ff != pos_ff);
            if (rdv_ff && (CW'(rdi_ff) == count_ff - CW'(1))) begin
               state_in = S_SWAP_A;
            end
         end
         S_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {best_tag, best_key};
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_data = {base_tag, base_key};
            pos_in  = pos_ff + AW'(1);
            if (CW'(pos_ff) + CW'(2) < count_ff) begin
               ptr_in   = CW'(pos_ff) + CW'(1);
               state_in = S_SCAN;
            end else begin
               ptr_in   = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = S_EMIT_DATA;
         end
         S_EMIT_DATA: begin
            if (out_free) begin
               emit_load = 1'b1;
               if (ptr_ff + CW'(1) == count_ff) begin
                  // list done: start a new one
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  ptr_in   = ptr_ff + CW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      rdv_in = rd_en && (state_ff == S_SCAN);
      rdi_in = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
         ptr_ff   <= '0;
         rdv_ff   <= 1'b0;
         rdi_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         ptr_ff   <= ptr_in;
         rdv_ff   <= rdv_in;
         rdi_ff   <= rdi_in;
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_key_ff  <= rd_data[KEY_BITS-1:0];
         rsp_tag_ff  <= rd_data[PW-1:KEY_BITS];
         rsp_last_ff <= (ptr_ff + CW'(1) == count_ff);
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'({rsp_tag_ff, rsp_key_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("entry count beyond store depth");

   // a sort pass only runs on a list of two or more pairs
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff >= CW'(2)))
      else $error("scan on a list shorter than two");

   // the selected maximum lies in the unsorted tail
   a_best_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_A) |-> ((best_idx >= pos_ff) && (CW'(best_idx) < count_ff)))
      else $error("swap partner outside the unsorted tail");

   // the final result closes the list
   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      (emit_load && (ptr_ff + CW'(1) == count_ff)) |=>
         ((count_ff == '0) && !ovf_ff && (state_ff == S_LOAD) && rsp_tlast))
      else $error("list not closed after final result");

   // no output load while a result is held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !emit_load)
      else $error("held result overwritten");

endmodule
